// ===== sv/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and codes of the text console core: request codes, internal
// command codes, and the command and result records.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Request codes as they arrive on req_type.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Command codes passed from the front end to the back end.
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Fixed character constants.
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Classified command; the cursor fields already hold the cursor after it.
  typedef struct packed {
    logic [1:0] op;
    logic       scroll;
    logic [7:0] char_code;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } cmd_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } res_t;

endpackage

// ===== sv/text_console_cursor_scroll_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text-mode console of ROWS x COLS character/attribute cells with a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: push with req_type, char_code,
//   cell_row and cell_col; a request is taken when push is high and full low.
//   Every request yields exactly one result, presented while empty is low and
//   taken when pop is high. Results leave in request order.
//   A front end keeps the cursor and classifies requests into a four-entry
//   command queue; a back end owns the screen store and executes commands.
//   Puts and no-ops give their result in the cycle the command is taken;
//   reads give it from ST_READ, behind the store's registered read port. A
//   scroll walks (ROWS-1)*COLS cells and a clear ROWS*COLS cells, one cell
//   per cycle through the single write port; later commands wait in the
//   queue meanwhile.
//   After reset the store is cleared, during which full is held high. If
//   the receiver stops popping, the two-entry result queue and then the
//   command queue fill, and full rises.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [4:0] cell_row,
  input  logic [6:0] cell_col,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col
);

  localparam int ADDR_W = $clog2(ROWS*COLS);
  localparam int CMD_W  = $bits(tccs_pkg::cmd_t) + ADDR_W;
  localparam int RES_W  = $bits(tccs_pkg::res_t);

  logic                 init_busy;
  logic                 cmd_full;
  logic                 cmd_push;
  tccs_pkg::cmd_t       cmd_in;
  logic [ADDR_W-1:0]    addr_in;
  logic [CMD_W-1:0]     cmd_head;
  logic                 cmd_empty;
  logic                 cmd_pop;
  tccs_pkg::cmd_t       cmd_out;
  logic [ADDR_W-1:0]    addr_out;
  logic                 res_full;
  logic                 res_push;
  tccs_pkg::res_t       res_in;
  logic [RES_W-1:0]     res_head;
  tccs_pkg::res_t       res_out;

  // Front end: cursor and request classification.
  tccs_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req_type  (req_type),
    .char_code (char_code),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .full      (full),
    .init_busy (init_busy),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_addr  (addr_in)
  );

  // Command queue between front and back ends.
  tccs_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata ({cmd_in, addr_in}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  assign cmd_out  = cmd_head[CMD_W-1:ADDR_W];
  assign addr_out = cmd_head[ADDR_W-1:0];

  // Back end: screen store and sweeps.
  tccs_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_addr  (addr_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .init_busy (init_busy)
  );

  // Result queue towards the receiver.
  tccs_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign res_out    = res_head;
  assign cell_char  = res_out.cell_char;
  assign cell_attr  = res_out.cell_attr;
  assign cursor_row = res_out.cursor_row;
  assign cursor_col = res_out.cursor_col;

endmodule

// ===== sv/tccs_fifo.sv =====
// ----------------------------------------------------------------------------
// tccs_fifo
// Small synchronous first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module tccs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/tccs_front.sv =====
// ----------------------------------------------------------------------------
// tccs_front
// Front end: accepts requests, keeps the cursor, and turns each request into
// one command with its cell address and the cursor that follows it.
// ----------------------------------------------------------------------------
module tccs_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [1:0]                        req_type,
  input  logic [7:0]                        char_code,
  input  logic [4:0]                        cell_row,
  input  logic [6:0]                        cell_col,
  output logic                              full,
  input  logic                              init_busy,
  input  logic                              cmd_full,
  output logic                              cmd_push,
  output tccs_pkg::cmd_t                    cmd,
  output logic [$clog2(ROWS*COLS)-1:0]      cmd_addr
);

  localparam int ADDR_W = $clog2(ROWS*COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS-1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS-1);

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [1:0]       op;
  logic             scroll;
  logic             accept;

  // Requests wait while the store is being cleared after reset.
  assign full     = cmd_full || init_busy;
  assign accept   = push && !full;
  assign cmd_push = accept;

  // Classify the request and work out the cursor that follows it.
  always_comb begin
    row_next = row;
    col_next = col;
    scroll   = 1'b0;
    op       = tccs_pkg::OP_NOP;
    cmd_addr = ADDR_W'(32'(row) * COLS + 32'(col));
    unique case (req_type)
      tccs_pkg::REQ_PUT: begin
        if (char_code != tccs_pkg::NEWLINE_CODE) begin
          op       = tccs_pkg::OP_WRITE;
          col_next = (col == COL_LAST) ? '0 : col + 1'b1;
        end else begin
          col_next = '0;
        end
        if (col_next == '0) begin
          if (row == ROW_LAST) begin
            scroll = 1'b1;
          end else begin
            row_next = row + 1'b1;
          end
        end
      end
      tccs_pkg::REQ_READ: begin
        cmd_addr = ADDR_W'(32'(cell_row) * COLS + 32'(cell_col));
        if (32'(cell_row) < ROWS && 32'(cell_col) < COLS) begin
          op = tccs_pkg::OP_READ;
        end
      end
      tccs_pkg::REQ_CLEAR: begin
        op = tccs_pkg::OP_CLEAR;
      end
      default: begin
        op = tccs_pkg::OP_NOP;
      end
    endcase
  end

  // Command record handed to the queue.
  always_comb begin
    cmd.op         = op;
    cmd.scroll     = scroll;
    cmd.char_code  = char_code;
    cmd.cursor_row = 5'(row_next);
    cmd.cursor_col = 7'(col_next);
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

// ===== sv/tccs_back.sv =====
// ----------------------------------------------------------------------------
// tccs_back
// Back end: owns the screen store and carries out commands in order, with
// sweeps for the clear after reset, clear requests and scrolling.
// ----------------------------------------------------------------------------
module tccs_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_empty,
  input  tccs_pkg::cmd_t               cmd,
  input  logic [$clog2(ROWS*COLS)-1:0] cmd_addr,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output tccs_pkg::res_t               res,
  output logic                         init_busy
);

  localparam int ADDR_W = $clog2(ROWS*COLS);
  localparam int CELLS  = ROWS*COLS;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CELLS-1);
  localparam logic [ADDR_W-1:0] SCR_LAST = ADDR_W'((ROWS-1)*COLS-1);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(COLS);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;
  logic              cp_pend;
  logic [ADDR_W-1:0] cp_addr;
  logic [4:0]        hold_row;
  logic [6:0]        hold_col;

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // Sequencer: one command at a time, sweeps walk the store a cell a cycle.
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    mem_we     = 1'b0;
    mem_waddr  = cmd_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = ptr + ROW_STEP;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        ptr_next  = ptr + 1'b1;
        if (ptr == CLR_LAST) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop        = 1'b1;
          res.cursor_row = cmd.cursor_row;
          res.cursor_col = cmd.cursor_col;
          unique case (cmd.op)
            tccs_pkg::OP_WRITE: begin
              mem_we    = 1'b1;
              mem_wdata = {tccs_pkg::ATTR_DEFAULT, cmd.char_code};
              res_push  = 1'b1;
            end
            tccs_pkg::OP_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = cmd_addr;
              state_next = ST_READ;
            end
            tccs_pkg::OP_CLEAR: begin
              res_push   = 1'b1;
              state_next = ST_CLEAR;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
          if (cmd.scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_READ: begin
        res_push       = 1'b1;
        res.cell_char  = mem_rdata[7:0];
        res.cell_attr  = mem_rdata[15:8];
        res.cursor_row = hold_row;
        res.cursor_col = hold_col;
        state_next     = ST_IDLE;
      end
      ST_SCROLL: begin
        mem_re   = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == SCR_LAST) begin
          ptr_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Second half of a scroll copy: write the row-below cell one row up.
    if (cp_pend) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr;
      mem_wdata = mem_rdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      cp_pend   <= 1'b0;
      init_busy <= 1'b1;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      cp_pend <= (state == ST_SCROLL);
      if (state == ST_CLEAR && ptr == CLR_LAST) begin
        init_busy <= 1'b0;
      end
    end
  end

  // Payload held across a read and a copy in flight.
  always_ff @(posedge clk) begin
    cp_addr <= ptr;
    if (cmd_pop) begin
      hold_row <= cmd.cursor_row;
      hold_col <= cmd.cursor_col;
    end
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // A result is only produced when the result queue has room for it.
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result produced into a full result queue");

  // A pending copy write never meets a new command.
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cp_pend)
    else $error("command taken while a scroll copy is still pending");

  // Reset always starts the clearing pass.
  assert property (@(posedge clk) rst |=> (state == ST_CLEAR && init_busy && ptr == '0))
    else $error("clearing pass not started after reset");

  // A read result always follows its command in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
      (cmd_pop && cmd.op == tccs_pkg::OP_READ && !cmd.scroll) |=> res_push)
    else $error("read result not delivered in the following cycle");

endmodule
